FILE: hw/rtl/cef_pkg.sv
// cef_pkg: shared types, constants and helper functions for conv_event_fanout
// no dependencies; used by every module of the block

package cef_pkg;

    localparam int MAX_FILTER = 8;
    localparam int MAX_DIM    = 1024;
    localparam int COORD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int FILT_W     = 4;
    localparam int OFS_W      = 3;
    localparam int PAD_W      = 3;
    localparam int CFG_W      = 11;
    localparam int IDX_W      = 3;
    localparam int DIV_STEPS  = DIM_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [IDX_W-1:0] {
        REG_PAD_X    = 3'd0,
        REG_PAD_Y    = 3'd1,
        REG_FILTER_W = 3'd2,
        REG_FILTER_H = 3'd3,
        REG_STEP_X   = 3'd4,
        REG_STEP_Y   = 3'd5,
        REG_ACTIVE_W = 3'd6,
        REG_ACTIVE_H = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [PAD_W-1:0]  pad_x;
        logic [PAD_W-1:0]  pad_y;
        logic [FILT_W-1:0] filter_w;
        logic [FILT_W-1:0] filter_h;
        logic [FILT_W-1:0] step_x;
        logic [FILT_W-1:0] step_y;
        logic [DIM_W-1:0]  active_w;
        logic [DIM_W-1:0]  active_h;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] in_x;
        logic [COORD_W-1:0] in_y;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [OFS_W-1:0]   weight_x;
        logic [OFS_W-1:0]   weight_y;
        logic               last;
    } out_item_t;

    // one lane of a window range
    typedef struct packed {
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        logic [OFS_W-1:0]   w0;
        logic               ok;
    } span_t;

    // scan job handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0] x_lo;
        logic [COORD_W-1:0] x_hi;
        logic [COORD_W-1:0] y_lo;
        logic [COORD_W-1:0] y_hi;
        logic [OFS_W-1:0]   wx0;
        logic [OFS_W-1:0]   wy0;
        logic [FILT_W-1:0]  sx;
        logic [FILT_W-1:0]  sy;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [FILT_W-1:0] clamp_filter(input logic [FILT_W-1:0] f);
        logic [FILT_W-1:0] r;
        if (f == '0)
            r = FILT_W'(1);
        else if (f > FILT_W'(MAX_FILTER))
            r = FILT_W'(MAX_FILTER);
        else
            r = f;
        return r;
    endfunction

    function automatic logic [FILT_W-1:0] clamp_stride(input logic [FILT_W-1:0] s,
                                                      input logic [FILT_W-1:0] f);
        logic [FILT_W-1:0] r;
        if (s == '0)
            r = FILT_W'(1);
        else if (s > f)
            r = f;
        else
            r = s;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] a);
        logic [DIM_W-1:0] r;
        if (a > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = a;
        return r;
    endfunction

    // q, r: quotient and remainder of the padded coordinate by the stride
    function automatic span_t lane_span(input logic [DIM_W-1:0]  q,
                                        input logic [OFS_W-1:0]  r,
                                        input logic [FILT_W-1:0] f,
                                        input logic [FILT_W-1:0] s,
                                        input logic [DIM_W-1:0]  a);
        span_t             sp;
        logic [OFS_W-1:0]  fm1;
        logic [OFS_W-1:0]  avail;
        logic [OFS_W-1:0]  k;
        logic [OFS_W-1:0]  kk;
        logic [6:0]        prod;
        logic [6:0]        back;
        logic [DIM_W-1:0]  lo;
        logic [DIM_W-1:0]  hi;
        fm1   = OFS_W'(f - FILT_W'(1));
        avail = fm1 - r;
        k     = '0;
        // windows further back that still cover the point
        for (int m = 1; m < MAX_FILTER; m++)
        begin
            prod = 7'(m) * {3'b000, s};
            if (prod <= {4'b0000, avail})
                k = OFS_W'(m);
        end
        if (DIM_W'(k) > q)
            kk = q[OFS_W-1:0];
        else
            kk = k;
        back  = {4'b0000, kk} * {3'b000, s};
        lo    = q - DIM_W'(kk);
        hi    = (q < a) ? q : a - DIM_W'(1);
        sp.lo = lo[COORD_W-1:0];
        sp.hi = hi[COORD_W-1:0];
        sp.w0 = r + back[OFS_W-1:0];
        sp.ok = (a != '0) && (lo <= hi);
        return sp;
    endfunction

endpackage

FILE: hw/rtl/cef_front.sv
// cef_front: accepts spike items, divides padded coordinates by the strides
// and pushes one scan job per covered item; uses cef_pkg

module cef_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cef_pkg::cfg_t         cfg,
    input  logic                  ev_valid,
    output logic                  ev_stall,
    input  cef_pkg::in_item_t     ev_data,
    output logic                  push,
    output cef_pkg::desc_t        desc,
    input  cef_pkg::fifo_stat_t   fstat
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_FIN  = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [cef_pkg::CNT_W-1:0]  cnt_reg;
    logic [cef_pkg::DIM_W-1:0]  qdx_reg, qdy_reg;
    logic [cef_pkg::OFS_W-1:0]  remx_reg, remy_reg;
    logic [cef_pkg::FILT_W-1:0] fw_reg, fh_reg, sx_reg, sy_reg;
    logic [cef_pkg::DIM_W-1:0]  aw_reg, ah_reg;

    logic                       accept;
    logic [cef_pkg::OFS_W:0]    tx, ty;
    logic                       gex, gey;
    logic [cef_pkg::OFS_W:0]    tx_sub, ty_sub;
    cef_pkg::span_t             spx, spy;
    logic [cef_pkg::FILT_W-1:0] fw_c, fh_c;

    assign ev_stall = (state_reg != F_IDLE);
    assign accept   = ev_valid && !ev_stall;
    assign fw_c     = cef_pkg::clamp_filter(cfg.filter_w);
    assign fh_c     = cef_pkg::clamp_filter(cfg.filter_h);

    // one restoring division step per lane
    assign tx     = {remx_reg, qdx_reg[cef_pkg::DIM_W-1]};
    assign ty     = {remy_reg, qdy_reg[cef_pkg::DIM_W-1]};
    assign gex    = (tx >= sx_reg);
    assign gey    = (ty >= sy_reg);
    assign tx_sub = tx - sx_reg;
    assign ty_sub = ty - sy_reg;

    assign spx = cef_pkg::lane_span(qdx_reg, remx_reg, fw_reg, sx_reg, aw_reg);
    assign spy = cef_pkg::lane_span(qdy_reg, remy_reg, fh_reg, sy_reg, ah_reg);

    assign desc.x_lo = spx.lo;
    assign desc.x_hi = spx.hi;
    assign desc.y_lo = spy.lo;
    assign desc.y_hi = spy.hi;
    assign desc.wx0  = spx.w0;
    assign desc.wy0  = spy.w0;
    assign desc.sx   = sx_reg;
    assign desc.sy   = sy_reg;

    assign push = (state_reg == F_FIN) && spx.ok && spy.ok && !fstat.full;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_DIV;
            end
            F_DIV:
            begin
                if (cnt_reg == cef_pkg::CNT_W'(cef_pkg::DIV_STEPS - 1))
                    state_next = F_FIN;
            end
            F_FIN:
            begin
                if (!(spx.ok && spy.ok) || !fstat.full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                cnt_reg <= '0;
            else if (state_reg == F_DIV)
                cnt_reg <= cnt_reg + cef_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qdx_reg  <= cef_pkg::DIM_W'(ev_data.in_x) + cef_pkg::DIM_W'(cfg.pad_x);
            qdy_reg  <= cef_pkg::DIM_W'(ev_data.in_y) + cef_pkg::DIM_W'(cfg.pad_y);
            remx_reg <= '0;
            remy_reg <= '0;
            fw_reg   <= fw_c;
            fh_reg   <= fh_c;
            sx_reg   <= cef_pkg::clamp_stride(cfg.step_x, fw_c);
            sy_reg   <= cef_pkg::clamp_stride(cfg.step_y, fh_c);
            aw_reg   <= cef_pkg::clamp_dim(cfg.active_w);
            ah_reg   <= cef_pkg::clamp_dim(cfg.active_h);
        end
        else if (state_reg == F_DIV)
        begin
            qdx_reg  <= {qdx_reg[cef_pkg::DIM_W-2:0], gex};
            qdy_reg  <= {qdy_reg[cef_pkg::DIM_W-2:0], gey};
            remx_reg <= gex ? tx_sub[cef_pkg::OFS_W-1:0] : tx[cef_pkg::OFS_W-1:0];
            remy_reg <= gey ? ty_sub[cef_pkg::OFS_W-1:0] : ty[cef_pkg::OFS_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/cef_fifo.sv
// cef_fifo: two-entry queue of scan jobs between front and back
// uses cef_pkg for the job type and depth constants

module cef_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cef_pkg::desc_t      wdata,
    input  logic                pop,
    output cef_pkg::desc_t      rdata,
    output cef_pkg::fifo_stat_t fstat
);

    cef_pkg::desc_t             mem_reg [cef_pkg::FIFO_DEPTH];
    logic [cef_pkg::PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [cef_pkg::LVL_W-1:0]  count_reg, count_next;
    logic                       do_push, do_pop;

    assign fstat.full  = (count_reg == cef_pkg::LVL_W'(cef_pkg::FIFO_DEPTH));
    assign fstat.empty = (count_reg == '0);
    assign do_push     = push && !fstat.full;
    assign do_pop      = pop && !fstat.empty;
    assign rdata       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + cef_pkg::LVL_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - cef_pkg::LVL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + cef_pkg::PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + cef_pkg::PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

FILE: hw/rtl/cef_back.sv
// cef_back: walks each scan job x outer, y inner, one result item per cycle while fan_stall
// does not hold the output register; uses cef_pkg

module cef_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cef_pkg::desc_t      desc,
    input  cef_pkg::fifo_stat_t fstat,
    output logic                pop,
    output logic                fan_valid,
    input  logic                fan_stall,
    output cef_pkg::out_item_t  fan_data
);

    logic                        active_reg;
    cef_pkg::desc_t              cur_reg;
    logic [cef_pkg::COORD_W-1:0] x_reg, y_reg;
    logic [cef_pkg::OFS_W-1:0]   wx_reg, wy_reg;
    logic                        fan_valid_reg;
    cef_pkg::out_item_t          fan_data_reg;
    logic                        emit;
    logic                        y_end, is_last;

    assign pop       = !active_reg && !fstat.empty;
    assign emit      = active_reg && (!fan_valid_reg || !fan_stall);
    assign y_end     = (y_reg == cur_reg.y_hi);
    assign is_last   = y_end && (x_reg == cur_reg.x_hi);
    assign fan_valid = fan_valid_reg;
    assign fan_data  = fan_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            fan_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                active_reg <= 1'b1;
            else if (emit && is_last)
                active_reg <= 1'b0;
            if (emit)
                fan_valid_reg <= 1'b1;
            else if (!fan_stall)
                fan_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= desc;
            x_reg   <= desc.x_lo;
            y_reg   <= desc.y_lo;
            wx_reg  <= desc.wx0;
            wy_reg  <= desc.wy0;
        end
        else if (emit)
        begin
            if (y_end)
            begin
                x_reg  <= x_reg + cef_pkg::COORD_W'(1);
                wx_reg <= wx_reg - cur_reg.sx[cef_pkg::OFS_W-1:0];
                y_reg  <= cur_reg.y_lo;
                wy_reg <= cur_reg.wy0;
            end
            else
            begin
                y_reg  <= y_reg + cef_pkg::COORD_W'(1);
                wy_reg <= wy_reg - cur_reg.sy[cef_pkg::OFS_W-1:0];
            end
        end
        if (emit)
        begin
            fan_data_reg.out_x    <= x_reg;
            fan_data_reg.out_y    <= y_reg;
            fan_data_reg.weight_x <= wx_reg;
            fan_data_reg.weight_y <= wy_reg;
            fan_data_reg.last     <= is_last;
        end
    end

endmodule

FILE: hw/rtl/conv_event_fanout.sv
// conv_event_fanout: top level, configuration registers, front, job queue and back
// depends on cef_pkg, cef_front, cef_fifo and cef_back
//
//   channel   direction  handshake               payload
//   ev        in         ev_valid / ev_stall     cef_pkg::in_item_t  (in_x, in_y)
//   fan       out        fan_valid / fan_stall   cef_pkg::out_item_t (out_x .. last)
//   cfg       in         cfg_we                  cfg_index, cfg_data
//
// the front takes one item at a time: accept, 11 divider steps, one finish
// the divider steps produce one quotient bit per cycle on both axes
// the back gives one result per cycle while fan_stall allows, after loading each job
// a two-entry job queue lets the front run ahead while results wait on fan_stall
// reset restores the documented register defaults; no clearing pass is needed

module conv_event_fanout (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cef_pkg::IDX_W-1:0]      cfg_index,
    input  logic [cef_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           ev_valid,
    output logic                           ev_stall,
    input  cef_pkg::in_item_t              ev_data,
    output logic                           fan_valid,
    input  logic                           fan_stall,
    output cef_pkg::out_item_t             fan_data
);

    cef_pkg::cfg_t       cfg_reg;
    logic                push, pop;
    cef_pkg::desc_t      wdesc, rdesc;
    cef_pkg::fifo_stat_t fstat;
    logic [cef_pkg::FILT_W-1:0] fw_c, fh_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pad_x    <= '0;
            cfg_reg.pad_y    <= '0;
            cfg_reg.filter_w <= cef_pkg::FILT_W'(3);
            cfg_reg.filter_h <= cef_pkg::FILT_W'(3);
            cfg_reg.step_x   <= cef_pkg::FILT_W'(1);
            cfg_reg.step_y   <= cef_pkg::FILT_W'(1);
            cfg_reg.active_w <= cef_pkg::DIM_W'(cef_pkg::MAX_DIM);
            cfg_reg.active_h <= cef_pkg::DIM_W'(cef_pkg::MAX_DIM);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cef_pkg::REG_PAD_X:    cfg_reg.pad_x    <= cfg_data[cef_pkg::PAD_W-1:0];
                cef_pkg::REG_PAD_Y:    cfg_reg.pad_y    <= cfg_data[cef_pkg::PAD_W-1:0];
                cef_pkg::REG_FILTER_W: cfg_reg.filter_w <= cfg_data[cef_pkg::FILT_W-1:0];
                cef_pkg::REG_FILTER_H: cfg_reg.filter_h <= cfg_data[cef_pkg::FILT_W-1:0];
                cef_pkg::REG_STEP_X:   cfg_reg.step_x   <= cfg_data[cef_pkg::FILT_W-1:0];
                cef_pkg::REG_STEP_Y:   cfg_reg.step_y   <= cfg_data[cef_pkg::FILT_W-1:0];
                cef_pkg::REG_ACTIVE_W: cfg_reg.active_w <= cfg_data[cef_pkg::DIM_W-1:0];
                cef_pkg::REG_ACTIVE_H: cfg_reg.active_h <= cfg_data[cef_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    cef_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .ev_valid (ev_valid),
        .ev_stall (ev_stall),
        .ev_data  (ev_data),
        .push     (push),
        .desc     (wdesc),
        .fstat    (fstat)
    );

    cef_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdesc),
        .pop   (pop),
        .rdata (rdesc),
        .fstat (fstat)
    );

    cef_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc      (rdesc),
        .fstat     (fstat),
        .pop       (pop),
        .fan_valid (fan_valid),
        .fan_stall (fan_stall),
        .fan_data  (fan_data)
    );

    assign fw_c = cef_pkg::clamp_filter(cfg_reg.filter_w);
    assign fh_c = cef_pkg::clamp_filter(cfg_reg.filter_h);

    // queue never reports full and empty at once
    a_fifo_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(fstat.full && fstat.empty))
        else $error("job queue full and empty together");

    // a job pushed into the queue is visible to the back next cycle
    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !fstat.empty)
        else $error("pushed job not in queue");

    // weight offsets stay inside the window
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        fan_valid |-> ({1'b0, fan_data.weight_x} < fw_c)
                   && ({1'b0, fan_data.weight_y} < fh_c))
        else $error("weight offset outside window");

endmodule

FILE: verif/testbench.sv
// testbench: self-checking bench for conv_event_fanout, a directed table then random layers
// depends on cef_pkg and the conv_event_fanout rtl; every fan-out item is predicted locally

module testbench;

    localparam int SETTLE         = 40;
    localparam int CYCLE_CAP      = 600000;
    localparam int PHASES         = 8;
    localparam int PER_PHASE      = 50;
    localparam int MOST_PER_SPIKE = 64;
    localparam int IDLE_PCT       = 17;

    typedef enum logic [1:0] {CHK_MODEL, CHK_ONE, CHK_NONE} check_t;
    typedef enum logic {ROW_REG, ROW_SPIKE} row_t;

    typedef struct {
        row_t                      kind;
        cef_pkg::reg_index_t       idx;
        logic [cef_pkg::CFG_W-1:0] value;
        cef_pkg::in_item_t         spike;
        check_t                    chk;
        cef_pkg::out_item_t        want;
    } step_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [cef_pkg::IDX_W-1:0] cfg_index = '0;
    logic [cef_pkg::CFG_W-1:0] cfg_data  = '0;
    logic                      ev_valid  = 1'b0;
    logic                      ev_stall;
    cef_pkg::in_item_t         ev_data   = '0;
    logic                      fan_valid;
    logic                      fan_stall = 1'b0;
    cef_pkg::out_item_t        fan_data;

    cef_pkg::cfg_t      layer;
    cef_pkg::out_item_t fanout_due[$];
    step_t              plan[$];
    int                 errors = 0;
    int                 cycles = 0;
    bit                 calm   = 1'b0;

    conv_event_fanout i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ev_valid  (ev_valid),
        .ev_stall  (ev_stall),
        .ev_data   (ev_data),
        .fan_valid (fan_valid),
        .fan_stall (fan_stall),
        .fan_data  (fan_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        fan_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void expect_item(input cef_pkg::out_item_t r);
        fanout_due.insert(fanout_due.size(), r);
    endfunction

    function automatic void add_row(input step_t s);
        plan.insert(plan.size(), s);
    endfunction

    function automatic void predict_fanout(input cef_pkg::in_item_t spike);
        int unsigned        fw, fh, sx, sy, aw, ah, px, py, x0, x1, y0, y1, n;
        cef_pkg::out_item_t r;
        fw = (layer.filter_w == 0) ? 1 :
             (layer.filter_w > cef_pkg::MAX_FILTER) ? cef_pkg::MAX_FILTER : layer.filter_w;
        fh = (layer.filter_h == 0) ? 1 :
             (layer.filter_h > cef_pkg::MAX_FILTER) ? cef_pkg::MAX_FILTER : layer.filter_h;
        sx = (layer.step_x == 0) ? 1 : (layer.step_x > fw) ? fw : layer.step_x;
        sy = (layer.step_y == 0) ? 1 : (layer.step_y > fh) ? fh : layer.step_y;
        aw = (layer.active_w > cef_pkg::MAX_DIM) ? cef_pkg::MAX_DIM : layer.active_w;
        ah = (layer.active_h > cef_pkg::MAX_DIM) ? cef_pkg::MAX_DIM : layer.active_h;
        px = spike.in_x + layer.pad_x;
        py = spike.in_y + layer.pad_y;
        // first window reaching back to the point, last window starting at or before it
        x0 = (px >= fw - sx) ? (px - (fw - sx)) / sx : 0;
        x1 = px / sx;
        y0 = (py >= fh - sy) ? (py - (fh - sy)) / sy : 0;
        y1 = py / sy;
        n  = 0;
        for (int unsigned x = x0; x <= x1 && x < aw; x++)
        begin
            for (int unsigned y = y0; y <= y1 && y < ah; y++)
            begin
                if (n < MOST_PER_SPIKE)
                begin
                    r.out_x    = cef_pkg::COORD_W'(x);
                    r.out_y    = cef_pkg::COORD_W'(y);
                    r.weight_x = cef_pkg::OFS_W'(px - x * sx);
                    r.weight_y = cef_pkg::OFS_W'(py - y * sy);
                    r.last     = 1'b0;
                    expect_item(r);
                    n++;
                end
            end
        end
        if (n > 0)
            fanout_due[fanout_due.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_fanout(input cef_pkg::out_item_t got);
        cef_pkg::out_item_t want;
        if (fanout_due.size() == 0)
        begin
            $error("unexpected item: out_x %0d out_y %0d", got.out_x, got.out_y);
            errors++;
        end
        else
        begin
            want = fanout_due.pop_front();
            check_field("out_x", want.out_x, got.out_x);
            check_field("out_y", want.out_y, got.out_y);
            check_field("weight_x", want.weight_x, got.weight_x);
            check_field("weight_y", want.weight_y, got.weight_y);
            check_field("last", want.last, got.last);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && fan_valid && !fan_stall)
            check_fanout(fan_data);
    end

    function automatic cef_pkg::out_item_t hit(input int unsigned x, input int unsigned y,
                                               input int unsigned wx, input int unsigned wy,
                                               input bit l);
        cef_pkg::out_item_t r;
        r.out_x    = cef_pkg::COORD_W'(x);
        r.out_y    = cef_pkg::COORD_W'(y);
        r.weight_x = cef_pkg::OFS_W'(wx);
        r.weight_y = cef_pkg::OFS_W'(wy);
        r.last     = l;
        return r;
    endfunction

    function automatic step_t reg_row(input cef_pkg::reg_index_t idx,
                                      input int unsigned value);
        step_t s;
        s.kind  = ROW_REG;
        s.idx   = idx;
        s.value = cef_pkg::CFG_W'(value);
        s.spike = '0;
        s.chk   = CHK_NONE;
        s.want  = '0;
        return s;
    endfunction

    function automatic step_t spike_row(input int unsigned x, input int unsigned y,
                                        input check_t chk, input cef_pkg::out_item_t want);
        step_t s;
        s.kind       = ROW_SPIKE;
        s.idx        = cef_pkg::REG_PAD_X;
        s.value      = '0;
        s.spike.in_x = cef_pkg::COORD_W'(x);
        s.spike.in_y = cef_pkg::COORD_W'(y);
        s.chk        = chk;
        s.want       = want;
        return s;
    endfunction

    task automatic send_spike(input cef_pkg::in_item_t spike, input check_t chk,
                              input cef_pkg::out_item_t want);
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            ev_valid <= 1'b0;
            @(negedge clk);
        end
        ev_valid <= 1'b1;
        ev_data  <= spike;
        do
            @(posedge clk);
        while (ev_stall);
        case (chk)
            CHK_MODEL: predict_fanout(spike);
            CHK_ONE:   expect_item(want);
            default:   ;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        ev_valid <= 1'b0;
        while (fanout_due.size() != 0)
            @(posedge clk);
        // spikes with no fan-out may still be in the front
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cef_pkg::reg_index_t idx, input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= cef_pkg::CFG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            cef_pkg::REG_PAD_X:    layer.pad_x    = cef_pkg::PAD_W'(value);
            cef_pkg::REG_PAD_Y:    layer.pad_y    = cef_pkg::PAD_W'(value);
            cef_pkg::REG_FILTER_W: layer.filter_w = cef_pkg::FILT_W'(value);
            cef_pkg::REG_FILTER_H: layer.filter_h = cef_pkg::FILT_W'(value);
            cef_pkg::REG_STEP_X:   layer.step_x   = cef_pkg::FILT_W'(value);
            cef_pkg::REG_STEP_Y:   layer.step_y   = cef_pkg::FILT_W'(value);
            cef_pkg::REG_ACTIVE_W: layer.active_w = cef_pkg::DIM_W'(value);
            default:               layer.active_h = cef_pkg::DIM_W'(value);
        endcase
    endtask

    function automatic int unsigned pick_filter();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 0 : $urandom_range(9, 15);
        return $urandom_range(1, cef_pkg::MAX_FILTER);
    endfunction

    function automatic int unsigned pick_stride(input int unsigned f);
        int unsigned eff;
        eff = (f == 0) ? 1 : (f > cef_pkg::MAX_FILTER) ? cef_pkg::MAX_FILTER : f;
        if ($urandom_range(9) == 0)
            return $urandom_range(0, 15);
        return $urandom_range(1, eff);
    endfunction

    function automatic int unsigned pick_active();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return cef_pkg::MAX_DIM;
        if (r < 70)
            return $urandom_range(cef_pkg::MAX_DIM + 1, 2047);
        if (r < 82)
            return $urandom_range(1, 64);
        if (r < 86)
            return 0;
        return $urandom_range(1, cef_pkg::MAX_DIM - 1);
    endfunction

    function automatic int unsigned pick_coord(input int unsigned extent);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            return $urandom_range(0, 15);
        if (r < 30)
            return $urandom_range(1008, 1023);
        if (r < 50)
            return $urandom_range(0, extent);
        return $urandom_range(0, 1023);
    endfunction

    initial
    begin : stimulus
        int unsigned       v[8];
        int unsigned       ext_x, ext_y;
        cef_pkg::in_item_t s;
        bit                dirty;

        layer.pad_x    = '0;
        layer.pad_y    = '0;
        layer.filter_w = cef_pkg::FILT_W'(3);
        layer.filter_h = cef_pkg::FILT_W'(3);
        layer.step_x   = cef_pkg::FILT_W'(1);
        layer.step_y   = cef_pkg::FILT_W'(1);
        layer.active_w = cef_pkg::DIM_W'(cef_pkg::MAX_DIM);
        layer.active_h = cef_pkg::DIM_W'(cef_pkg::MAX_DIM);
        dirty = 1'b0;

        // reset layer: 3x3 window, unit stride, no padding
        add_row(spike_row(0, 0, CHK_ONE, hit(0, 0, 0, 0, 1)));
        add_row(spike_row(1023, 1023, CHK_MODEL, '0));
        add_row(spike_row(1023, 0, CHK_MODEL, '0));
        add_row(spike_row(0, 1023, CHK_MODEL, '0));
        add_row(spike_row(682, 341, CHK_MODEL, '0));
        // non-overlapping 2x2 windows
        add_row(reg_row(cef_pkg::REG_FILTER_W, 2));
        add_row(reg_row(cef_pkg::REG_FILTER_H, 2));
        add_row(reg_row(cef_pkg::REG_STEP_X, 2));
        add_row(reg_row(cef_pkg::REG_STEP_Y, 2));
        add_row(spike_row(0, 0, CHK_ONE, hit(0, 0, 0, 0, 1)));
        add_row(spike_row(1023, 1023, CHK_ONE, hit(511, 511, 1, 1, 1)));
        add_row(spike_row(341, 682, CHK_MODEL, '0));
        // out-of-range filter and stride codes, full padding
        add_row(reg_row(cef_pkg::REG_PAD_X, 7));
        add_row(reg_row(cef_pkg::REG_PAD_Y, 7));
        add_row(reg_row(cef_pkg::REG_FILTER_W, 0));
        add_row(reg_row(cef_pkg::REG_FILTER_H, 15));
        add_row(reg_row(cef_pkg::REG_STEP_X, 0));
        add_row(reg_row(cef_pkg::REG_STEP_Y, 15));
        add_row(spike_row(0, 0, CHK_ONE, hit(7, 0, 0, 7, 1)));
        add_row(spike_row(1023, 1023, CHK_NONE, '0));
        add_row(spike_row(1016, 5, CHK_ONE, hit(1023, 1, 0, 4, 1)));
        // zero active width
        add_row(reg_row(cef_pkg::REG_ACTIVE_W, 0));
        add_row(spike_row(5, 5, CHK_NONE, '0));
        // widest fan-out, active size beyond the limit
        add_row(reg_row(cef_pkg::REG_ACTIVE_W, 2047));
        add_row(reg_row(cef_pkg::REG_ACTIVE_H, 2047));
        add_row(reg_row(cef_pkg::REG_PAD_X, 0));
        add_row(reg_row(cef_pkg::REG_PAD_Y, 0));
        add_row(reg_row(cef_pkg::REG_FILTER_W, 8));
        add_row(reg_row(cef_pkg::REG_FILTER_H, 8));
        add_row(reg_row(cef_pkg::REG_STEP_X, 1));
        add_row(reg_row(cef_pkg::REG_STEP_Y, 1));
        add_row(spike_row(0, 0, CHK_ONE, hit(0, 0, 0, 0, 1)));
        add_row(spike_row(500, 600, CHK_MODEL, '0));
        add_row(spike_row(1023, 1023, CHK_MODEL, '0));
        // padding not below the window, stride above the window on x and equal to it on y
        add_row(reg_row(cef_pkg::REG_PAD_X, 7));
        add_row(reg_row(cef_pkg::REG_PAD_Y, 3));
        add_row(reg_row(cef_pkg::REG_FILTER_W, 3));
        add_row(reg_row(cef_pkg::REG_FILTER_H, 3));
        add_row(reg_row(cef_pkg::REG_STEP_X, 9));
        add_row(reg_row(cef_pkg::REG_STEP_Y, 3));
        add_row(spike_row(0, 0, CHK_MODEL, '0));
        add_row(spike_row(1, 2, CHK_MODEL, '0));
        add_row(spike_row(1023, 1023, CHK_MODEL, '0));
        // single active neuron
        add_row(reg_row(cef_pkg::REG_PAD_X, 0));
        add_row(reg_row(cef_pkg::REG_PAD_Y, 0));
        add_row(reg_row(cef_pkg::REG_FILTER_W, 4));
        add_row(reg_row(cef_pkg::REG_FILTER_H, 4));
        add_row(reg_row(cef_pkg::REG_STEP_X, 1));
        add_row(reg_row(cef_pkg::REG_STEP_Y, 1));
        add_row(reg_row(cef_pkg::REG_ACTIVE_W, 1));
        add_row(reg_row(cef_pkg::REG_ACTIVE_H, 1));
        add_row(spike_row(0, 0, CHK_ONE, hit(0, 0, 0, 0, 1)));
        add_row(spike_row(3, 3, CHK_ONE, hit(0, 0, 3, 3, 1)));
        add_row(spike_row(4, 0, CHK_NONE, '0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < plan.size(); i++)
        begin
            if (plan[i].kind == ROW_REG)
            begin
                if (dirty)
                    drain();
                dirty = 1'b0;
                write_reg(plan[i].idx, plan[i].value);
            end
            else
            begin
                send_spike(plan[i].spike, plan[i].chk, plan[i].want);
                dirty = 1'b1;
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            calm = (phase == 2);
            if (phase == 0)
            begin
                v[cef_pkg::REG_PAD_X]    = 7;
                v[cef_pkg::REG_PAD_Y]    = 7;
                v[cef_pkg::REG_FILTER_W] = cef_pkg::MAX_FILTER;
                v[cef_pkg::REG_FILTER_H] = cef_pkg::MAX_FILTER;
                v[cef_pkg::REG_STEP_X]   = 1;
                v[cef_pkg::REG_STEP_Y]   = 1;
                v[cef_pkg::REG_ACTIVE_W] = cef_pkg::MAX_DIM;
                v[cef_pkg::REG_ACTIVE_H] = cef_pkg::MAX_DIM;
            end
            else if (phase == 1)
            begin
                v[cef_pkg::REG_PAD_X]    = 7;
                v[cef_pkg::REG_PAD_Y]    = 7;
                v[cef_pkg::REG_FILTER_W] = cef_pkg::MAX_FILTER;
                v[cef_pkg::REG_FILTER_H] = cef_pkg::MAX_FILTER;
                v[cef_pkg::REG_STEP_X]   = cef_pkg::MAX_FILTER;
                v[cef_pkg::REG_STEP_Y]   = cef_pkg::MAX_FILTER;
                v[cef_pkg::REG_ACTIVE_W] = 2047;
                v[cef_pkg::REG_ACTIVE_H] = 2047;
            end
            else
            begin
                v[cef_pkg::REG_PAD_X]    = $urandom_range(0, 7);
                v[cef_pkg::REG_PAD_Y]    = $urandom_range(0, 7);
                v[cef_pkg::REG_FILTER_W] = pick_filter();
                v[cef_pkg::REG_FILTER_H] = pick_filter();
                v[cef_pkg::REG_STEP_X]   = pick_stride(v[cef_pkg::REG_FILTER_W]);
                v[cef_pkg::REG_STEP_Y]   = pick_stride(v[cef_pkg::REG_FILTER_H]);
                v[cef_pkg::REG_ACTIVE_W] = pick_active();
                v[cef_pkg::REG_ACTIVE_H] = pick_active();
            end
            for (int r = 0; r < 8; r++)
                write_reg(cef_pkg::reg_index_t'(r), v[r]);

            // aim part of the spikes at the edge of the active area
            ext_x = v[cef_pkg::REG_ACTIVE_W]
                    * ((v[cef_pkg::REG_STEP_X] == 0) ? 1 : v[cef_pkg::REG_STEP_X]) + 8;
            ext_y = v[cef_pkg::REG_ACTIVE_H]
                    * ((v[cef_pkg::REG_STEP_Y] == 0) ? 1 : v[cef_pkg::REG_STEP_Y]) + 8;
            if (ext_x > 1023)
                ext_x = 1023;
            if (ext_y > 1023)
                ext_y = 1023;

            for (int k = 0; k < PER_PHASE; k++)
            begin
                s.in_x = cef_pkg::COORD_W'(pick_coord(ext_x));
                s.in_y = cef_pkg::COORD_W'(pick_coord(ext_y));
                send_spike(s, CHK_MODEL, '0);
                if ($urandom_range(29) == 0)
                    drain();
            end
        end

        drain();
        if (errors == 0 && fanout_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/cef_pkg.sv
hw/rtl/cef_front.sv
hw/rtl/cef_fifo.sv
hw/rtl/cef_back.sv
hw/rtl/conv_event_fanout.sv
verif/testbench.sv
